/* hdl/tsp_pkg.sv */
// Timestamp text parser package: types, constants and small character helpers.
// Used by the channel consumers, the scan stage, the judge and the top level.
// No dependencies.
package tsp_pkg;

  localparam logic [4:0] TS_LEN   = 5'd20;
  localparam logic [2:0] NO_DAY   = 3'd7;
  localparam int unsigned NumDays = 7;
  localparam int unsigned NumFlds = 6;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SHORT    = 4'd1;
  localparam logic [3:0] ST_DATE_SEP = 4'd2;
  localparam logic [3:0] ST_TIME_SEP = 4'd3;
  localparam logic [3:0] ST_DAY      = 4'd4;
  localparam logic [3:0] ST_DATE     = 4'd5;
  localparam logic [3:0] ST_MONTH    = 4'd6;
  localparam logic [3:0] ST_YEAR     = 4'd7;
  localparam logic [3:0] ST_HOURS    = 4'd8;
  localparam logic [3:0] ST_MINUTES  = 4'd9;
  localparam logic [3:0] ST_SECONDS  = 4'd10;

  localparam logic [7:0] DATE_MAX   = 8'h31;
  localparam logic [7:0] MONTH_MAX  = 8'h12;
  localparam logic [7:0] HOUR_MAX   = 8'h24;
  localparam logic [7:0] MINSEC_MAX = 8'h59;
  localparam logic [6:0] HOUR_FLAG  = 7'h40;

  localparam int unsigned FLAG_DATE_SEP = 0;
  localparam int unsigned FLAG_TIME_SEP = 1;
  localparam logic [3:0]  FLAG_FIELD0   = 4'd2;

  localparam logic [7:0] DAY_FIRST [NumDays] = '{"S", "M", "D", "M", "D", "F", "S"};
  localparam logic [7:0] DAY_SECOND[NumDays] = '{"o", "o", "i", "i", "o", "r", "a"};
  localparam logic [7:0] SEP_CHAR  [NumFlds] = '{" ", ".", ".", " ", ":", ":"};

  typedef enum logic [2:0] {
    SLOT_FIRST,
    SLOT_SECOND,
    SLOT_SEP,
    SLOT_HI,
    SLOT_LO,
    SLOT_NONE
  } slot_kind_t;

  typedef struct packed {
    slot_kind_t kind;
    logic [2:0] idx;
  } slot_t;

  typedef struct packed {
    logic [4:0]      pos;
    logic [7:0]      first;
    logic [2:0]      day;
    logic [3:0]      pend;
    logic [5:0][7:0] field;
    logic [9:0]      flags;
  } scan_t;

  typedef struct packed {
    logic [3:0] status;
    logic [2:0] day_index;
    logic [5:0] date_bcd;
    logic [4:0] month_bcd;
    logic [7:0] year_bcd;
    logic [6:0] hours_reg;
    logic [6:0] minutes_bcd;
    logic [6:0] seconds_bcd;
  } result_t;

  function automatic slot_t slot_of(logic [4:0] pos);
    slot_t s;
    s = '{kind: SLOT_NONE, idx: 3'd0};
    case (pos)
      5'd0:  s.kind = SLOT_FIRST;
      5'd1:  s.kind = SLOT_SECOND;
      5'd2:  s = '{kind: SLOT_SEP, idx: 3'd0};
      5'd3:  s = '{kind: SLOT_HI,  idx: 3'd0};
      5'd4:  s = '{kind: SLOT_LO,  idx: 3'd0};
      5'd5:  s = '{kind: SLOT_SEP, idx: 3'd1};
      5'd6:  s = '{kind: SLOT_HI,  idx: 3'd1};
      5'd7:  s = '{kind: SLOT_LO,  idx: 3'd1};
      5'd8:  s = '{kind: SLOT_SEP, idx: 3'd2};
      5'd9:  s = '{kind: SLOT_HI,  idx: 3'd2};
      5'd10: s = '{kind: SLOT_LO,  idx: 3'd2};
      5'd11: s = '{kind: SLOT_SEP, idx: 3'd3};
      5'd12: s = '{kind: SLOT_HI,  idx: 3'd3};
      5'd13: s = '{kind: SLOT_LO,  idx: 3'd3};
      5'd14: s = '{kind: SLOT_SEP, idx: 3'd4};
      5'd15: s = '{kind: SLOT_HI,  idx: 3'd4};
      5'd16: s = '{kind: SLOT_LO,  idx: 3'd4};
      5'd17: s = '{kind: SLOT_SEP, idx: 3'd5};
      5'd18: s = '{kind: SLOT_HI,  idx: 3'd5};
      5'd19: s = '{kind: SLOT_LO,  idx: 3'd5};
      default: s = '{kind: SLOT_NONE, idx: 3'd0};
    endcase
    return s;
  endfunction

  function automatic logic [7:0] to_up(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_low(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

endpackage

/* hdl/tsp_if.sv */
// Valid/ready channel interfaces for the timestamp text parser.
// Character word in, decoded result word out. No dependencies.
interface tsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source(output valid, char_code, last_char, input ready);
  modport sink(input valid, char_code, last_char, output ready);
endinterface

interface tsp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [2:0] day_index;
  logic [5:0] date_bcd;
  logic [4:0] month_bcd;
  logic [7:0] year_bcd;
  logic [6:0] hours_reg;
  logic [6:0] minutes_bcd;
  logic [6:0] seconds_bcd;

  modport source(output valid, status, day_index, date_bcd, month_bcd, year_bcd,
                 hours_reg, minutes_bcd, seconds_bcd, input ready);
  modport sink(input valid, status, day_index, date_bcd, month_bcd, year_bcd,
               hours_reg, minutes_bcd, seconds_bcd, output ready);
endinterface

/* hdl/tsp_scan.sv */
// Scan stage: position counter, weekday match, separator and digit checks.
// Holds the per-string state and presents it updated by the current character.
// Depends on tsp_pkg.
module tsp_scan (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    char_code,
  input  logic          last_char,
  output tsp_pkg::scan_t st_upd
);
  import tsp_pkg::*;

  scan_t state_r;
  scan_t state_nxt;
  slot_t slot;

  always_comb begin
    slot   = slot_of(state_r.pos);
    st_upd = state_r;
    if (state_r.pos != TS_LEN) begin
      st_upd.pos = state_r.pos + 5'd1;
      case (slot.kind)
        SLOT_FIRST: st_upd.first = to_up(char_code);
        SLOT_SECOND: begin
          st_upd.day = NO_DAY;
          for (int i = NumDays - 1; i >= 0; i--) begin
            if (state_r.first == DAY_FIRST[i] && to_low(char_code) == DAY_SECOND[i]) begin
              st_upd.day = 3'(i);
            end
          end
        end
        SLOT_SEP: begin
          if (char_code != SEP_CHAR[slot.idx]) begin
            if (slot.idx < 3'd3) begin
              st_upd.flags[FLAG_DATE_SEP] = 1'b1;
            end else begin
              st_upd.flags[FLAG_TIME_SEP] = 1'b1;
            end
          end
        end
        SLOT_HI, SLOT_LO: begin
          if (!is_dig(char_code)) begin
            st_upd.flags[{1'b0, slot.idx} + FLAG_FIELD0] = 1'b1;
            st_upd.pend = 4'd0;
          end else if (slot.kind == SLOT_HI) begin
            st_upd.pend = char_code[3:0];
          end else begin
            st_upd.field[slot.idx] = {state_r.pend, char_code[3:0]};
          end
        end
        default: st_upd = st_upd;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (take) begin
      state_nxt = last_char ? '0 : st_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pos <= TS_LEN) else $error("position past string length");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && last_char |=> state_r == '0) else $error("state not cleared after last word");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    take && !last_char && state_r.pos < TS_LEN |=> state_r.pos == $past(state_r.pos) + 5'd1)
    else $error("position did not advance");

endmodule

/* hdl/tsp_judge.sv */
// Judge: picks the first failing check and packs the result word.
// Purely combinational on the updated scan state. Depends on tsp_pkg.
module tsp_judge (
  input  tsp_pkg::scan_t   st,
  output tsp_pkg::result_t res
);
  import tsp_pkg::*;

  logic [7:0] f0, f1, f3, f4, f5;
  logic [3:0] status;

  assign f0 = st.field[0];
  assign f1 = st.field[1];
  assign f3 = st.field[3];
  assign f4 = st.field[4];
  assign f5 = st.field[5];

  always_comb begin
    if (st.pos < TS_LEN) begin
      status = ST_SHORT;
    end else if (st.flags[FLAG_DATE_SEP]) begin
      status = ST_DATE_SEP;
    end else if (st.flags[FLAG_TIME_SEP]) begin
      status = ST_TIME_SEP;
    end else if (st.day == NO_DAY) begin
      status = ST_DAY;
    end else if (st.flags[2] || f0 == 8'd0 || f0 > DATE_MAX) begin
      status = ST_DATE;
    end else if (st.flags[3] || f1 == 8'd0 || f1 > MONTH_MAX) begin
      status = ST_MONTH;
    end else if (st.flags[4]) begin
      status = ST_YEAR;
    end else if (st.flags[5] || f3 > HOUR_MAX) begin
      status = ST_HOURS;
    end else if (st.flags[6] || f4 > MINSEC_MAX) begin
      status = ST_MINUTES;
    end else if (st.flags[7] || f5 > MINSEC_MAX) begin
      status = ST_SECONDS;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.day_index   = st.day;
      res.date_bcd    = f0[5:0];
      res.month_bcd   = f1[4:0];
      res.year_bcd    = st.field[2];
      res.hours_reg   = f3[6:0] | HOUR_FLAG;
      res.minutes_bcd = f4[6:0];
      res.seconds_bcd = f5[6:0];
    end
  end

endmodule

/* hdl/timestamp_text_parser_top.sv */
// Timestamp text parser top level: input register, scan, judge, result register.
// Depends on tsp_pkg, tsp_if, tsp_scan and tsp_judge.
//
// Usage:
//   in_chan carries one ASCII character per word ("Dd DD.MM.YY hh:mm:ss"),
//   last_char set on the final character of a string. Characters past the
//   twentieth are ignored.
//   out_chan carries one result word per string, issued for the word with
//   last_char set: status and packed-BCD fields (all fields zero on error).
// Timing:
//   A character is captured in the input register at acceptance and folded
//   into the scan state as it leaves; a last character's result word passes
//   the input and result registers. One word is accepted every cycle unless
//   a final character is held; the state update is the limiting path.
// Stall:
//   While a result waits on out_chan.ready, non-final characters keep
//   flowing; a second final character holds in the input register until
//   the result register frees, and in_chan.ready drops behind it.
// Reset:
//   rst_n low clears both valid flags and the scan state; a word held at
//   reset is dropped and no word is issued across reset.
module timestamp_text_parser_top (
  input logic clk,
  input logic rst_n,
  tsp_in_if.sink    in_chan,
  tsp_out_if.source out_chan
);
  import tsp_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;

  logic    out_free;
  logic    s1_fire;
  logic    in_take;
  scan_t   st_upd;
  result_t res;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && (!s1_last_r || out_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_take       = in_chan.valid && in_chan.ready;

  tsp_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (s1_fire),
    .char_code (s1_char_r),
    .last_char (s1_last_r),
    .st_upd    (st_upd)
  );

  tsp_judge u_judge (
    .st  (st_upd),
    .res (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_chan.char_code;
      s1_last_r <= in_chan.last_char;
    end
    if (s1_fire && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_res_r.status;
  assign out_chan.day_index   = out_res_r.day_index;
  assign out_chan.date_bcd    = out_res_r.date_bcd;
  assign out_chan.month_bcd   = out_res_r.month_bcd;
  assign out_chan.year_bcd    = out_res_r.year_bcd;
  assign out_chan.hours_reg   = out_res_r.hours_reg;
  assign out_chan.minutes_bcd = out_res_r.minutes_bcd;
  assign out_chan.seconds_bcd = out_res_r.seconds_bcd;

  a_ok_hour_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status == ST_OK |-> out_res_r.hours_reg[6])
    else $error("good result without hour flag");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status != ST_OK |->
      out_res_r.day_index == 3'd0 && out_res_r.date_bcd == 6'd0 &&
      out_res_r.month_bcd == 5'd0 && out_res_r.year_bcd == 8'd0 &&
      out_res_r.hours_reg == 7'd0 && out_res_r.minutes_bcd == 7'd0 &&
      out_res_r.seconds_bcd == 7'd0)
    else $error("error result with nonzero fields");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("result without a last word");

endmodule
